>>> hw/rtl/rotary_encoder_frontend_defines.svh
// Assertion macros for the rotary encoder front end.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef ROTARY_ENCODER_FRONTEND_DEFINES_SVH
`define ROTARY_ENCODER_FRONTEND_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define RENC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("renc invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define RENC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("renc same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RENC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("renc next-cycle check failed");

`endif

>>> hw/rtl/renc_pkg.sv
// Types and constants for the rotary encoder front end.
// No dependencies; imported by rotary_encoder_frontend.
package renc_pkg;

    // Item kinds
    localparam logic [2:0] KIND_PIN       = 3'd0;
    localparam logic [2:0] KIND_TICK      = 3'd1;
    localparam logic [2:0] KIND_DIRECTION = 3'd2;
    localparam logic [2:0] KIND_DELTA     = 3'd3;
    localparam logic [2:0] KIND_BUTTON    = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUTTON_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION_DEBOUNCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLITCH_SAMPLES    = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] BUTTON_DEBOUNCE_RESET   = 16'd50;
    localparam logic [15:0] ROTATION_DEBOUNCE_RESET = 16'd50;
    localparam logic [9:0]  GLITCH_SAMPLES_RESET    = 10'd80;

    localparam logic signed [8:0] COUNT_LIMIT    = 9'sd100;
    localparam logic [16:0]       PRESS_GUARD_MS = 17'd20;
    localparam logic [9:0]        RUN_MAX        = 10'h3FF;

    typedef struct packed {
        logic [2:0] kind;
        logic       level_a;
        logic       level_b;
        logic       button_level;
    } item_in_t;

    typedef struct packed {
        logic signed [1:0] direction;
        logic signed [7:0] delta;
        logic              pressed;
    } item_out_t;

    typedef struct packed {
        logic       hit;
        logic       level;
        logic [9:0] run;
    } filt_result_t;

endpackage

>>> hw/rtl/rotary_encoder_frontend.sv
// Rotary encoder front end: glitch filter, x4 quadrature counter, button debounce.
// Depends on renc_pkg and rotary_encoder_frontend_defines.svh.
// Pipeline: an input transfer loads the input register; out_valid rises when the result register loads.
// Throughput: one item per cycle unless out_ready stalls; each item is one pass through the logic between the two.
// Reset (async, rst_n low): clock, stamps, count and flags clear, filtered A/B and last
// button sample go high, debounces reset to 50 ms and the glitch filter to 80 samples.
`include "rotary_encoder_frontend_defines.svh"

module rotary_encoder_frontend
    import renc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  item_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output item_out_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    function automatic filt_result_t filter_step(input logic raw, input logic filt,
                                                 input logic [9:0] run,
                                                 input logic [9:0] need);
        filt_result_t r;
        logic [9:0] run_inc;
        r.hit   = 1'b0;
        r.level = filt;
        r.run   = '0;
        run_inc = (run != RUN_MAX) ? run + 10'd1 : run;
        if (raw != filt)
        begin
            if (run_inc >= need)
            begin
                r.hit   = 1'b1;
                r.level = raw;
            end
            else
            begin
                r.run = run_inc;
            end
        end
        return r;
    endfunction

    function automatic logic signed [7:0] count_step(input logic signed [7:0] c,
                                                     input logic up);
        logic signed [8:0] sum;
        sum = {c[7], c} + (up ? 9'sd1 : -9'sd1);
        if (sum >= COUNT_LIMIT || sum <= -COUNT_LIMIT)
            return '0;
        return sum[7:0];
    endfunction

    // Configuration
    logic [15:0] btn_deb_reg;
    logic [15:0] rot_deb_reg;
    logic [9:0]  glitch_reg;

    // Input and result stages
    logic      s1_valid_reg;
    item_in_t  s1_data_reg;
    logic      out_valid_reg;
    item_out_t out_data_reg;
    item_out_t out_data_next;

    // Block state
    logic [31:0]       now_reg,       now_next;
    logic [31:0]       last_btn_reg,  last_btn_next;
    logic [31:0]       last_rot_reg,  last_rot_next;
    logic              pending_reg,   pending_next;
    logic signed [7:0] count_reg,     count_next;
    logic              filt_a_reg,    filt_a_next;
    logic              filt_b_reg,    filt_b_next;
    logic [9:0]        run_a_reg,     run_a_next;
    logic [9:0]        run_b_reg,     run_b_next;
    logic              btn_last_reg,  btn_last_next;

    logic              out_adv;
    logic              proc;
    filt_result_t      fa;
    filt_result_t      fb;
    logic signed [7:0] count_a;
    logic [31:0]       btn_elapsed;
    logic [31:0]       rot_elapsed;
    logic [16:0]       press_need;
    logic [2:0]        out_nonzero;

    assign out_adv   = !out_valid_reg || out_ready;
    assign proc      = s1_valid_reg && out_adv;
    assign in_ready  = !s1_valid_reg || out_adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_deb_reg <= BUTTON_DEBOUNCE_RESET;
            rot_deb_reg <= ROTATION_DEBOUNCE_RESET;
            glitch_reg  <= GLITCH_SAMPLES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUTTON_DEBOUNCE:   btn_deb_reg <= cfg_data;
                CFG_ROTATION_DEBOUNCE: rot_deb_reg <= (cfg_data == '0) ?
                                                      ROTATION_DEBOUNCE_RESET : cfg_data;
                CFG_GLITCH_SAMPLES:    glitch_reg  <= cfg_data[9:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (proc)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            last_btn_reg <= '0;
            last_rot_reg <= '0;
            pending_reg  <= 1'b0;
            count_reg    <= '0;
            filt_a_reg   <= 1'b1;
            filt_b_reg   <= 1'b1;
            run_a_reg    <= '0;
            run_b_reg    <= '0;
            btn_last_reg <= 1'b1;
        end
        else
        begin
            now_reg      <= now_next;
            last_btn_reg <= last_btn_next;
            last_rot_reg <= last_rot_next;
            pending_reg  <= pending_next;
            count_reg    <= count_next;
            filt_a_reg   <= filt_a_next;
            filt_b_reg   <= filt_b_next;
            run_a_reg    <= run_a_next;
            run_b_reg    <= run_b_next;
            btn_last_reg <= btn_last_next;
        end
    end

    // Elapsed times are wrap-safe 32-bit differences
    assign btn_elapsed = now_reg - last_btn_reg;
    assign rot_elapsed = now_reg - last_rot_reg;
    assign press_need  = {1'b0, rot_deb_reg} + PRESS_GUARD_MS;

    assign fa = filter_step(s1_data_reg.level_a, filt_a_reg, run_a_reg, glitch_reg);
    assign fb = filter_step(s1_data_reg.level_b, filt_b_reg, run_b_reg, glitch_reg);

    // Each edge is judged against the other channel's level from before this sample
    assign count_a = fa.hit ? count_step(count_reg, s1_data_reg.level_a != filt_b_reg)
                            : count_reg;

    always_comb
    begin
        now_next      = now_reg;
        last_btn_next = last_btn_reg;
        last_rot_next = last_rot_reg;
        pending_next  = pending_reg;
        count_next    = count_reg;
        filt_a_next   = filt_a_reg;
        filt_b_next   = filt_b_reg;
        run_a_next    = run_a_reg;
        run_b_next    = run_b_reg;
        btn_last_next = btn_last_reg;
        out_data_next = '0;

        if (proc)
        begin
            case (s1_data_reg.kind)
                KIND_PIN:
                begin
                    filt_a_next = fa.level;
                    run_a_next  = fa.run;
                    filt_b_next = fb.level;
                    run_b_next  = fb.run;
                    count_next  = fb.hit ?
                                  count_step(count_a, s1_data_reg.level_b == filt_a_reg) :
                                  count_a;
                    if (btn_last_reg && !s1_data_reg.button_level &&
                        btn_elapsed > {16'd0, btn_deb_reg})
                    begin
                        pending_next  = 1'b1;
                        last_btn_next = now_reg;
                    end
                    btn_last_next = s1_data_reg.button_level;
                end
                KIND_TICK:
                begin
                    now_next = now_reg + 32'd1;
                end
                KIND_DIRECTION:
                begin
                    count_next = '0;
                    if (count_reg != '0)
                    begin
                        last_rot_next = now_reg;
                        // Inside the lockout the count is dropped with no direction
                        if (rot_elapsed >= {16'd0, rot_deb_reg})
                            out_data_next.direction = count_reg[7] ? -2'sd1 : 2'sd1;
                    end
                end
                KIND_DELTA:
                begin
                    out_data_next.delta = count_reg;
                    count_next          = '0;
                end
                KIND_BUTTON:
                begin
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        out_data_next.pressed = !btn_last_reg &&
                                                (rot_elapsed >= {15'd0, press_need});
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_nonzero = {out_data_reg.direction != 2'sd0, out_data_reg.delta != 8'sd0,
                          out_data_reg.pressed};

    `RENC_ASSERT_ALWAYS(a_count_range, (count_reg < COUNT_LIMIT) && (count_reg > -COUNT_LIMIT))
    `RENC_ASSERT_NEXT(a_stage_drains, s1_valid_reg && !out_valid_reg, out_valid_reg)
    `RENC_ASSERT_SAME(a_one_field, out_valid_reg, $countones(out_nonzero) <= 1)
    `RENC_ASSERT_NEXT(a_delta_clears, proc && (s1_data_reg.kind == KIND_DELTA), count_reg == 8'sd0)
    `RENC_ASSERT_NEXT(a_button_consumes, proc && (s1_data_reg.kind == KIND_BUTTON), !pending_reg)

endmodule
